### hw/rtl/ekcc_pkg.sv
// shared types and constants for the expiring keyed challenge cache
// used by ekcc_ctrl, the top level and the testbench; depends on nothing
`default_nettype none

package ekcc_pkg;

  // slot count and derived widths
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int LIFE_W  = 32;
  localparam int TIME_W  = 40;
  localparam int TOK_W   = 64;
  localparam int SLOT_W  = 4;

  // register reset values
  localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(15000000);
  localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(10);

  // register indexes
  localparam logic [3:0] REG_LIFETIME = 4'd0;
  localparam logic [3:0] REG_CAPACITY = 4'd1;

  // request kinds
  localparam logic REQ_STORE  = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_REMOVED = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic              key_present;
    logic [TOK_W-1:0]  lookup_key;
    logic [TOK_W-1:0]  new_salt;
    logic [TOK_W-1:0]  new_challenge;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_used;
    logic [TOK_W-1:0]  found_salt;
    logic [TOK_W-1:0]  found_challenge;
  } res_t;

  typedef struct packed {
    logic [LIFE_W-1:0] lifetime_ticks;
    logic [CAP_W-1:0]  capacity;
  } cfg_t;

  // one stored record as it sits in the slot memory
  typedef struct packed {
    logic [TIME_W-1:0] tstamp;
    logic [TOK_W-1:0]  challenge;
    logic [TOK_W-1:0]  salt;
    logic [TOK_W-1:0]  key;
  } slot_t;

  // slot memory write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } ram_wr_t;

endpackage

`default_nettype wire

### hw/rtl/expiring_keyed_challenge_cache.sv
// flow: an accepted request scans the allocated slots in order and stops at the
// first match; when all allocated slots miss, or none are allocated, a resolve step
// follows; an empty key skips both; the result then passes the output register
// throughput: one request at a time (accept, scan, resolve, result); the scan reads
// one slot per cycle from the slot memory
// reset: valid bits and slot count clear at once, registers take their reset
// values; slot contents stay undefined and need no clearing pass
`default_nettype none

module expiring_keyed_challenge_cache
  import ekcc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // request channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // lookup_key[63:0], new_salt[127:64], new_challenge[191:128], now[231:192]
  input  wire logic [231:0] in_tdata,
  // req_type[0], key_present[1]
  input  wire logic [1:0]   in_tuser,
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // slot_used[3:0], found_salt[67:4], found_challenge[131:68], zero[135:132]
  output logic [135:0]      out_tdata,
  // status[1:0]
  output logic [1:0]        out_tuser,
  // configuration write channel
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  cfg_t             cfg_r;
  req_t             req;
  res_t             res;
  logic             res_valid;
  logic             res_ready;
  logic [IDX_W-1:0] ram_rd_addr;
  slot_t            ram_rd_data;
  ram_wr_t          ram_wr;
  logic             out_valid_r;
  res_t             out_res_r;

  // configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lifetime_ticks <= LIFETIME_RESET;
      cfg_r.capacity       <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIFETIME: cfg_r.lifetime_ticks <= cfg_data;
        REG_CAPACITY: cfg_r.capacity       <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack the request
  assign req = '{req_type: in_tuser[0], key_present: in_tuser[1],
                 lookup_key: in_tdata[63:0], new_salt: in_tdata[127:64],
                 new_challenge: in_tdata[191:128], now: in_tdata[231:192]};

  ekcc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req         (req),
    .cfg         (cfg_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .ram_wr      (ram_wr)
  );

  ekcc_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // output register between the sequencer and the result channel
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {4'b0, out_res_r.found_challenge, out_res_r.found_salt,
                       out_res_r.slot_used};

endmodule

`default_nettype wire

### hw/rtl/ekcc_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module ekcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/ekcc_ctrl.sv
// request sequencer: scans the slot memory, picks the target slot, writes back
// depends on ekcc_pkg; drives the ekcc_ram ports through the top level
`default_nettype none

module ekcc_ctrl
  import ekcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire req_t              req,
  input  wire cfg_t              cfg,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output res_t                   res,
  output logic [IDX_W-1:0]       ram_rd_addr,
  input  wire slot_t             ram_rd_data,
  output ram_wr_t                ram_wr
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_RESOLVE = 2'd2;
  localparam logic [1:0] S_DONE    = 2'd3;

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [1:0]        state_r, state_nxt;
  req_t              req_r, req_nxt;
  res_t              res_r, res_nxt;
  logic [IDX_W-1:0]  eval_idx_r, eval_idx_nxt;
  logic [IDX_W-1:0]  slot_idx_r, slot_idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic              have_old_r, have_old_nxt;
  logic [IDX_W-1:0]  oldest_idx_r, oldest_idx_nxt;
  logic [TIME_W-1:0] oldest_time_r, oldest_time_nxt;

  logic              ent_valid;
  logic              key_eq;
  logic [TIME_W:0]   limit;
  logic              expired;
  logic              hit;
  logic              last;
  logic              older;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  eff_cap;
  logic              can_append;
  logic [IDX_W-1:0]  target;

  // compare the entry that came back from memory against the request
  always_comb begin
    ent_valid = valid_r[eval_idx_r];
    key_eq    = (ram_rd_data.key == req_r.lookup_key);
    limit     = {1'b0, ram_rd_data.tstamp} + (TIME_W + 1)'(cfg.lifetime_ticks);
    expired   = (limit < {1'b0, req_r.now});
    if (req_r.req_type == REQ_STORE) begin
      hit = !ent_valid || key_eq || expired;
    end else begin
      hit = ent_valid && key_eq;
    end
    last  = (CNT_W'(eval_idx_r) == (count_r - CNT_W'(1)));
    older = !have_old_r || (oldest_time_r > ram_rd_data.tstamp);
  end

  // capacity clamped to one..ENTRIES
  always_comb begin
    cap_ext = CMP_W'(cfg.capacity);
    if (cap_ext == CMP_W'(0)) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    can_append = (CMP_W'(count_r) < eff_cap);
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    res_nxt         = res_r;
    eval_idx_nxt    = eval_idx_r;
    slot_idx_nxt    = slot_idx_r;
    count_nxt       = count_r;
    valid_nxt       = valid_r;
    have_old_nxt    = have_old_r;
    oldest_idx_nxt  = oldest_idx_r;
    oldest_time_nxt = oldest_time_r;
    target          = eval_idx_r;
    req_ready       = 1'b0;
    res_valid       = 1'b0;
    ram_wr.en       = 1'b0;
    ram_wr.data     = '{tstamp: req_r.now, challenge: req_r.new_challenge,
                        salt: req_r.new_salt, key: req_r.lookup_key};

    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt      = req;
          eval_idx_nxt = IDX_W'(0);
          have_old_nxt = 1'b0;
          if (!req.key_present) begin
            res_nxt   = '{status: ST_EMPTY, slot_used: '0, found_salt: '0,
                          found_challenge: '0};
            state_nxt = S_DONE;
          end else if (count_r == CNT_W'(0)) begin
            state_nxt = S_RESOLVE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          slot_idx_nxt = eval_idx_r;
          if (req_r.req_type == REQ_STORE) begin
            ram_wr.en             = 1'b1;
            valid_nxt[eval_idx_r] = 1'b1;
            res_nxt = '{status: ST_STORED, slot_used: SLOT_W'(eval_idx_r),
                        found_salt: '0, found_challenge: '0};
          end else begin
            valid_nxt[eval_idx_r] = 1'b0;
            res_nxt = '{status: ST_REMOVED, slot_used: SLOT_W'(eval_idx_r),
                        found_salt: ram_rd_data.salt,
                        found_challenge: ram_rd_data.challenge};
          end
          state_nxt = S_DONE;
        end else begin
          // track the oldest non-qualifying slot, first one on ties
          if (older) begin
            have_old_nxt    = 1'b1;
            oldest_idx_nxt  = eval_idx_r;
            oldest_time_nxt = ram_rd_data.tstamp;
          end
          if (last) begin
            state_nxt = S_RESOLVE;
          end else begin
            eval_idx_nxt = eval_idx_r + IDX_W'(1);
          end
        end
      end

      S_RESOLVE: begin
        if (req_r.req_type == REQ_STORE) begin
          if (can_append) begin
            target    = IDX_W'(count_r);
            count_nxt = count_r + CNT_W'(1);
          end else begin
            target = oldest_idx_r;
          end
          ram_wr.en         = 1'b1;
          valid_nxt[target] = 1'b1;
          slot_idx_nxt      = target;
          res_nxt = '{status: ST_STORED, slot_used: SLOT_W'(target),
                      found_salt: '0, found_challenge: '0};
        end else begin
          res_nxt = '{status: ST_MISSING, slot_used: '0, found_salt: '0,
                      found_challenge: '0};
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // write port; a read may meet a write on one entry, but that read data is never
    // used since a write only happens on the last step of a request
    ram_wr.addr = target;
  end

  // read address runs one ahead of the entry being compared
  assign ram_rd_addr = (state_r == S_IDLE) ? IDX_W'(0) : eval_idx_r + IDX_W'(1);

  assign res = res_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      valid_r    <= '0;
      have_old_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      valid_r    <= valid_nxt;
      have_old_r <= have_old_nxt;
    end
  end

  // request payload and scan bookkeeping
  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    res_r         <= res_nxt;
    eval_idx_r    <= eval_idx_nxt;
    slot_idx_r    <= slot_idx_nxt;
    oldest_idx_r  <= oldest_idx_nxt;
    oldest_time_r <= oldest_time_nxt;
  end

  // a stored slot is marked valid by the time its result is offered
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r.status == ST_STORED) |-> valid_r[slot_idx_r])
    else $error("stored slot not marked valid");

  // a removed slot is freed by the time its result is offered
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r.status == ST_REMOVED) |-> !valid_r[slot_idx_r])
    else $error("removed slot still valid");

  // the slot count only grows, one at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    (!$stable(count_r) && $past(rst_n)) |-> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("slot count changed by other than one");

  // the slot count never runs past the memory depth
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("slot count beyond depth");

  // every write back is followed by the result step
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.en |=> (state_r == S_DONE))
    else $error("write back outside the final step");

endmodule

`default_nettype wire

### tb/expiring_keyed_challenge_cache_tb.sv
// self-checking testbench for expiring_keyed_challenge_cache: directed and random requests,
// results checked against an in-bench model of the slot cache
// depends on ekcc_pkg and the expiring_keyed_challenge_cache rtl
module expiring_keyed_challenge_cache_tb;
  import ekcc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int POOL_SIZE   = 12;

  typedef enum logic [1:0] {PLAN_REQ, PLAN_CFG, PLAN_SYNC} plan_kind_e;

  // one entry of the stimulus plan
  typedef struct {
    plan_kind_e        kind;
    req_t              req;
    logic [3:0]        reg_idx;
    logic [31:0]       reg_val;
    bit                calm;
  } plan_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [231:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [3:0]   cfg_index;
  logic [31:0]  cfg_data;

  plan_t plan_q[$];
  res_t  due_replies[$];
  int    fails;
  int    cycles;
  bit    in_fire;
  bit    cfg_fire;
  bit    calm;
  int    in_gap;
  int    out_stall;

  // cache model state and register copies
  logic              rec_valid [ENTRIES];
  logic [TOK_W-1:0]  rec_key   [ENTRIES];
  logic [TOK_W-1:0]  rec_salt  [ENTRIES];
  logic [TOK_W-1:0]  rec_chal  [ENTRIES];
  logic [TIME_W-1:0] rec_time  [ENTRIES];
  int                rec_count;
  logic [LIFE_W-1:0] life_ticks;
  logic [CAP_W-1:0]  cap_limit;

  expiring_keyed_challenge_cache dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // apply one request to the cache model and return its result
  function automatic res_t apply_request(input req_t r);
    res_t             res;
    int               cnt;
    int               cap;
    int               tgt;
    int               oldest;
    bit               hit;
    bit               have_old;
    logic [TIME_W:0]  limit_t;
    res = '0;
    cnt = rec_count;
    if (cnt > ENTRIES) cnt = ENTRIES;
    if (!r.key_present) begin
      res.status = ST_EMPTY;
      return res;
    end
    if (r.req_type == REQ_STORE) begin
      cap = int'(cap_limit);
      if (cap < 1) cap = 1;
      if (cap > ENTRIES) cap = ENTRIES;
      tgt = 0;
      oldest = 0;
      hit = 1'b0;
      have_old = 1'b0;
      // first free, same-key or expired slot wins; track the oldest on the way
      for (int i = 0; i < cnt && !hit; i++) begin
        limit_t = {1'b0, rec_time[i]} + (TIME_W+1)'(life_ticks);
        if (!rec_valid[i] || rec_key[i] == r.lookup_key || limit_t < {1'b0, r.now}) begin
          tgt = i;
          hit = 1'b1;
        end else if (!have_old || rec_time[oldest] > rec_time[i]) begin
          oldest = i;
          have_old = 1'b1;
        end
      end
      if (!hit) begin
        if (cnt < cap) begin
          tgt = cnt;
          rec_count = cnt + 1;
        end else begin
          tgt = oldest;
        end
      end
      rec_valid[tgt] = 1'b1;
      rec_key[tgt]   = r.lookup_key;
      rec_salt[tgt]  = r.new_salt;
      rec_chal[tgt]  = r.new_challenge;
      rec_time[tgt]  = r.now;
      res.status     = ST_STORED;
      res.slot_used  = tgt[SLOT_W-1:0];
      return res;
    end
    // remove: first valid slot holding the key, expiry ignored
    for (int i = 0; i < cnt; i++) begin
      if (rec_valid[i] && rec_key[i] == r.lookup_key) begin
        rec_valid[i]        = 1'b0;
        res.status          = ST_REMOVED;
        res.slot_used       = i[SLOT_W-1:0];
        res.found_salt      = rec_salt[i];
        res.found_challenge = rec_chal[i];
        return res;
      end
    end
    res.status = ST_MISSING;
    return res;
  endfunction

  task automatic push_req(input logic kind, input logic present, input logic [63:0] key,
                          input logic [63:0] salt, input logic [63:0] chal,
                          input logic [39:0] t, input bit quiet);
    plan_t p;
    p.kind              = PLAN_REQ;
    p.req.req_type      = kind;
    p.req.key_present   = present;
    p.req.lookup_key    = key;
    p.req.new_salt      = salt;
    p.req.new_challenge = chal;
    p.req.now           = t;
    p.reg_idx           = '0;
    p.reg_val           = '0;
    p.calm              = quiet;
    plan_q.push_back(p);
  endtask

  // wait for the cache to drain, then write both registers
  task automatic push_settings(input logic [31:0] life, input logic [31:0] cap);
    plan_t p;
    p.kind    = PLAN_SYNC;
    p.req     = '0;
    p.reg_idx = '0;
    p.reg_val = '0;
    p.calm    = 1'b0;
    plan_q.push_back(p);
    p.kind    = PLAN_CFG;
    p.reg_idx = REG_LIFETIME;
    p.reg_val = life;
    plan_q.push_back(p);
    p.reg_idx = REG_CAPACITY;
    p.reg_val = cap;
    plan_q.push_back(p);
  endtask

  // driver: request and config channels, result-side backpressure
  always @(negedge clk) begin : drive_p
    logic  nx_in_valid;
    logic  nx_cfg_valid;
    plan_t step;
    nx_in_valid  = in_tvalid;
    nx_cfg_valid = cfg_valid;
    if (rst_n) begin
      // result stalls in bursts
      if (out_stall == 0 && !calm && $urandom_range(0, 99) < 12)
        out_stall = $urandom_range(1, 9);
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall--;
      end else begin
        out_tready <= 1'b1;
      end
      if (in_fire) nx_in_valid = 1'b0;
      if (cfg_fire) nx_cfg_valid = 1'b0;
      if (!nx_in_valid && !nx_cfg_valid && plan_q.size() > 0) begin
        step = plan_q[0];
        case (step.kind)
          PLAN_SYNC: begin
            if (due_replies.size() == 0) void'(plan_q.pop_front());
          end
          PLAN_CFG: begin
            if (due_replies.size() == 0) begin
              void'(plan_q.pop_front());
              nx_cfg_valid = 1'b1;
              cfg_index <= step.reg_idx;
              cfg_data  <= step.reg_val;
            end
          end
          default: begin
            if (in_gap > 0) begin
              in_gap--;
            end else if (!step.calm && $urandom_range(0, 99) < 20) begin
              in_gap = $urandom_range(1, 9) - 1;
            end else begin
              void'(plan_q.pop_front());
              calm = step.calm;
              nx_in_valid = 1'b1;
              in_tdata <= {step.req.now, step.req.new_challenge, step.req.new_salt,
                           step.req.lookup_key};
              in_tuser <= {step.req.key_present, step.req.req_type};
            end
          end
        endcase
      end
    end
    in_tvalid <= nx_in_valid;
    cfg_valid <= nx_cfg_valid;
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin : watch_p
    req_t r;
    res_t want;
    cycles++;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LIFETIME) life_ticks = cfg_data;
        else if (cfg_index == REG_CAPACITY) cap_limit = cfg_data[CAP_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        r.req_type      = in_tuser[0];
        r.key_present   = in_tuser[1];
        r.lookup_key    = in_tdata[63:0];
        r.new_salt      = in_tdata[127:64];
        r.new_challenge = in_tdata[191:128];
        r.now           = in_tdata[231:192];
        due_replies.push_back(apply_request(r));
      end
      if (out_tvalid && out_tready) begin
        if (due_replies.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = due_replies.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            fails++;
          end
          if (out_tdata[3:0] !== want.slot_used) begin
            $error("slot_used: expected %0d, got %0d", want.slot_used, out_tdata[3:0]);
            fails++;
          end
          if (out_tdata[67:4] !== want.found_salt) begin
            $error("found_salt: expected %h, got %h", want.found_salt, out_tdata[67:4]);
            fails++;
          end
          if (out_tdata[131:68] !== want.found_challenge) begin
            $error("found_challenge: expected %h, got %h", want.found_challenge,
                   out_tdata[131:68]);
            fails++;
          end
        end
      end
    end
    in_fire  <= rst_n && in_tvalid && in_tready;
    cfg_fire <= rst_n && cfg_valid && cfg_ready;
    if (cycles > CYCLE_LIMIT) begin
      $display("expiring_keyed_challenge_cache_tb NOT OK");
      $finish;
    end
  end

  initial begin : stim_p
    logic [63:0] pool [POOL_SIZE];
    logic [31:0] ph_life [8];
    logic [31:0] ph_cap  [8];
    logic [63:0] ones;
    logic [63:0] key;
    logic [39:0] clock_us;
    logic [31:0] step_max;
    logic        kind;
    logic        present;
    int          per_phase;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    fails      = 0;
    cycles     = 0;
    calm       = 1'b0;
    in_gap     = 0;
    out_stall  = 0;
    rec_count  = 0;
    life_ticks = LIFETIME_RESET;
    cap_limit  = CAPACITY_RESET;
    ones       = '1;
    per_phase  = 98;
    for (int i = 0; i < ENTRIES; i++) begin
      rec_valid[i] = 1'b0;
      rec_key[i]   = '0;
      rec_salt[i]  = '0;
      rec_chal[i]  = '0;
      rec_time[i]  = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = {$urandom, $urandom};

    // directed part at reset settings: empty key, hit, miss, free reuse, expiry
    push_req(REQ_STORE, 1'b0, pool[0], ones, ones, 40'd5, 1'b0);
    push_req(REQ_REMOVE, 1'b0, pool[0], ones, ones, 40'd5, 1'b0);
    push_req(REQ_REMOVE, 1'b1, pool[0], '0, '0, 40'd50, 1'b0);
    push_req(REQ_STORE, 1'b1, pool[0], pool[5], pool[6], 40'd100, 1'b0);
    push_req(REQ_STORE, 1'b1, pool[1], pool[7], pool[8], 40'd200, 1'b0);
    push_req(REQ_STORE, 1'b1, pool[0], pool[9], pool[10], 40'd300, 1'b0);
    push_req(REQ_REMOVE, 1'b1, pool[1], '0, '0, 40'd310, 1'b0);
    push_req(REQ_STORE, 1'b1, pool[2], pool[11], pool[3], 40'd320, 1'b0);
    push_req(REQ_REMOVE, 1'b1, pool[1], '0, '0, 40'd330, 1'b0);
    push_req(REQ_STORE, 1'b1, ones, ones, ones, 40'hFF_FFFF_FFFF, 1'b0);
    push_req(REQ_REMOVE, 1'b1, ones, '0, '0, 40'hFF_FFFF_FFFF, 1'b0);
    push_req(REQ_STORE, 1'b1, '0, '0, '0, '0, 1'b0);
    push_req(REQ_REMOVE, 1'b1, '0, ones, ones, ones[39:0], 1'b0);

    // short lifetime, two slots: expiry, overwrite of the oldest, equal-time boundary
    push_settings(32'd50, 32'd2);
    push_req(REQ_STORE, 1'b1, pool[3], pool[4], pool[5], 40'd1000, 1'b0);
    push_req(REQ_STORE, 1'b1, pool[4], pool[5], pool[6], 40'd1001, 1'b0);
    push_req(REQ_STORE, 1'b1, pool[5], pool[6], pool[7], 40'd1010, 1'b0);
    push_req(REQ_STORE, 1'b1, pool[6], pool[7], pool[8], 40'd1061, 1'b0);
    push_req(REQ_STORE, 1'b1, pool[7], pool[8], pool[9], 40'd1051, 1'b0);

    // capacity zero acts as one, below the allocated count
    push_settings(32'hFFFF_FFFF, 32'd0);
    push_req(REQ_STORE, 1'b1, pool[8], pool[9], pool[10], 40'd2000, 1'b0);
    push_req(REQ_STORE, 1'b1, pool[9], pool[10], pool[11], 40'd2001, 1'b0);

    // random phases, each under its own settings
    ph_life = '{32'd0, 32'd200, 32'd5000, 32'hFFFF_FFFF, 32'd1, $urandom, 32'd15000000,
                $urandom};
    ph_cap  = '{32'd16, 32'd31, 32'd4, 32'd1, 32'd0, $urandom_range(0, 31), 32'd10, 32'd8};
    clock_us = 40'd5000;
    for (int ph = 0; ph < 8; ph++) begin
      push_settings(ph_life[ph], ph_cap[ph]);
      step_max = (ph_life[ph] >> 2) + 32'd2;
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 99) < 4) clock_us = 40'({$urandom, $urandom});
        else clock_us = clock_us + 40'($urandom_range(0, step_max));
        present = ($urandom_range(0, 99) >= 5);
        kind = ($urandom_range(0, 99) < 42) ? REQ_REMOVE : REQ_STORE;
        if ($urandom_range(0, 99) < 80) key = pool[$urandom_range(0, POOL_SIZE - 1)];
        else key = {$urandom, $urandom};
        push_req(kind, present, key, {$urandom, $urandom}, {$urandom, $urandom}, clock_us,
                 (ph == 7) && (n >= per_phase - 80));
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // drain, then a short tail to catch stray results
    do @(posedge clk);
    while (plan_q.size() != 0 || due_replies.size() != 0 || in_tvalid || cfg_valid);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0 && due_replies.size() == 0) begin
      $display("expiring_keyed_challenge_cache_tb OK");
    end else begin
      $display("expiring_keyed_challenge_cache_tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ekcc_pkg.sv
hw/rtl/ekcc_ram.sv
hw/rtl/ekcc_ctrl.sv
hw/rtl/expiring_keyed_challenge_cache.sv
tb/expiring_keyed_challenge_cache_tb.sv
